// File: design/tthb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tthb_pkg
// Types and constants shared by the tunnel to IPv6 header builder.
// ----------------------------------------------------------------------------
package tthb_pkg;

  // input transaction: one tunnel frame byte with its sideband
  typedef struct packed {
    logic [7:0]  frame_byte;
    logic        frame_first;
    logic        frame_last;
    logic [15:0] frame_len;
    logic [63:0] sender_hi;
    logic [63:0] sender_lo;
  } in_item_t;

  // output transaction: one IPv6 packet byte
  typedef struct packed {
    logic [7:0] pkt_byte;
    logic       pkt_first;
    logic       pkt_last;
    logic       to_sender;
  } out_item_t;

  // frame phase codes
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_WAIT = 2'd1;
  localparam logic [1:0] PH_PASS = 2'd2;
  localparam logic [1:0] PH_DROP = 2'd3;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_DEVICE_ADDR_HI = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_DEVICE_ADDR_LO = 1'b1;

  // frame and header constants
  localparam logic [7:0]  HDR_VERSION    = 8'h60;
  localparam logic [7:0]  HOP_LIMIT      = 8'd3;
  localparam logic [7:0]  MCAST_LEAD     = 8'hFF;
  localparam logic [7:0]  MCAST_TAG      = 8'h01;
  localparam logic [7:0]  GROUP_LEAD     = 8'hFF;
  localparam logic [15:0] UCAST_MIN_LEN  = 16'd2;
  localparam logic [15:0] MCAST_MIN_LEN  = 16'd20;
  localparam logic [15:0] UCAST_HDR_LEN  = 16'd1;
  localparam logic [15:0] MCAST_HDR_LEN  = 16'd19;

  // burst position of the payload byte that closes the header burst
  localparam logic [5:0] UCAST_FINAL_POS = 6'd40;
  localparam logic [5:0] MCAST_FINAL_POS = 6'd24;

endpackage
`default_nettype wire

// File: design/tunnel_to_ipv6_header_builder_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// A result is taken into the output register at the clock edge that accepts its input transaction.
// Throughput: passed payload bytes flow at one per cycle while out_ready holds; the decision byte
// of a frame starts a header burst of 41 (unicast) or 25 (multicast) bytes from the burst counter,
// and input is held off until the burst counter has sent the last byte of the burst.
// Reset: synchronous active-high rst clears phase, burst, output valid and device address.
// ----------------------------------------------------------------------------
// tunnel_to_ipv6_header_builder_unit
// Classifies tunnel frames as unicast or multicast and rebuilds them as IPv6
// packets: fixed header, sender address, destination address, then payload.
// ----------------------------------------------------------------------------
module tunnel_to_ipv6_header_builder_unit
  import tthb_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [63:0]            cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire in_item_t               in_data,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output out_item_t                   out_data
);

  // configuration
  logic [63:0] device_addr_hi;
  logic [63:0] device_addr_lo;

  // frame state
  logic [1:0]  phase;
  logic [1:0]  byte_index;
  logic [7:0]  lead_byte;
  logic [7:0]  protocol;
  logic [63:0] sender_hi;
  logic [63:0] sender_lo;
  logic [15:0] held_length;
  logic        mcast;

  // header burst
  logic        burst_active;
  logic [5:0]  burst_pos;
  logic [7:0]  burst_byte;
  logic        burst_last;

  logic [1:0]  phase_next;
  logic [1:0]  byte_index_next;
  logic [1:0]  index_inc;
  logic        mcast_next;
  logic [7:0]  protocol_next;
  logic        emit_single;
  logic        emit_burst;
  logic        out_free;
  logic        accept;
  logic [5:0]  final_pos;
  logic [15:0] payload_len;
  logic [5:0]  sel;
  out_item_t   gen_item;

  assign out_free = !out_valid || out_ready;
  assign in_ready = out_free && !burst_active;
  assign accept   = in_valid && in_ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      device_addr_hi <= '0;
      device_addr_lo <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DEVICE_ADDR_HI: device_addr_hi <= cfg_data;
        REG_DEVICE_ADDR_LO: device_addr_lo <= cfg_data;
        default: ;
      endcase
    end
  end

  // frame classification for the accepted byte
  always_comb begin
    phase_next      = phase;
    byte_index_next = byte_index;
    mcast_next      = mcast;
    protocol_next   = protocol;
    emit_single     = 1'b0;
    emit_burst      = 1'b0;
    index_inc       = (byte_index == 2'd3) ? byte_index : byte_index + 2'd1;
    if (in_data.frame_first) begin
      byte_index_next = 2'd0;
      protocol_next   = in_data.frame_byte;
      mcast_next      = 1'b0;
      if (in_data.frame_last) begin
        phase_next = PH_IDLE;
      end else if (in_data.frame_len < UCAST_MIN_LEN) begin
        phase_next = PH_DROP;
      end else begin
        phase_next = PH_WAIT;
      end
    end else if (phase != PH_IDLE) begin
      byte_index_next = index_inc;
      case (phase)
        PH_DROP: begin
          if (in_data.frame_last) phase_next = PH_IDLE;
        end
        PH_PASS: begin
          emit_single = 1'b1;
          if (in_data.frame_last) phase_next = PH_IDLE;
        end
        PH_WAIT: begin
          if (index_inc == 2'd1) begin
            if (lead_byte == MCAST_LEAD && in_data.frame_byte == MCAST_TAG) begin
              // multicast tag seen, protocol and group follow
              mcast_next = 1'b1;
              if (in_data.frame_last) begin
                phase_next = PH_IDLE;
              end else if (held_length < MCAST_MIN_LEN) begin
                phase_next = PH_DROP;
              end
            end else begin
              // unicast: header goes out now
              mcast_next = 1'b0;
              emit_burst = 1'b1;
              phase_next = in_data.frame_last ? PH_IDLE : PH_PASS;
            end
          end else if (index_inc == 2'd2) begin
            protocol_next = in_data.frame_byte;
            if (in_data.frame_last) phase_next = PH_IDLE;
          end else if (in_data.frame_byte != GROUP_LEAD) begin
            phase_next = in_data.frame_last ? PH_IDLE : PH_DROP;
          end else begin
            // valid group address start, multicast header goes out
            emit_burst = 1'b1;
            phase_next = in_data.frame_last ? PH_IDLE : PH_PASS;
          end
        end
        default: ;
      endcase
    end
  end

  // frame state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      byte_index <= 2'd0;
      mcast      <= 1'b0;
    end else if (accept) begin
      phase      <= phase_next;
      byte_index <= byte_index_next;
      mcast      <= mcast_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      protocol <= protocol_next;
      if (in_data.frame_first) begin
        lead_byte   <= in_data.frame_byte;
        held_length <= in_data.frame_len;
        sender_hi   <= in_data.sender_hi;
        sender_lo   <= in_data.sender_lo;
      end
    end
  end

  // header byte generator for the burst position
  assign final_pos   = mcast ? MCAST_FINAL_POS : UCAST_FINAL_POS;
  assign payload_len = held_length - (mcast ? MCAST_HDR_LEN : UCAST_HDR_LEN);
  assign sel         = {~burst_pos[2:0], 3'b000};

  always_comb begin
    gen_item.pkt_first = 1'b0;
    gen_item.pkt_last  = 1'b0;
    gen_item.to_sender = !mcast;
    gen_item.pkt_byte  = 8'd0;
    case (burst_pos[5:3])
      3'd0: begin
        case (burst_pos[2:0])
          3'd4:    gen_item.pkt_byte = payload_len[15:8];
          3'd5:    gen_item.pkt_byte = payload_len[7:0];
          3'd6:    gen_item.pkt_byte = protocol;
          3'd7:    gen_item.pkt_byte = HOP_LIMIT;
          default: gen_item.pkt_byte = 8'd0;
        endcase
      end
      3'd1:    gen_item.pkt_byte = sender_hi[sel +: 8];
      3'd2:    gen_item.pkt_byte = sender_lo[sel +: 8];
      3'd3:    gen_item.pkt_byte = device_addr_hi[sel +: 8];
      3'd4:    gen_item.pkt_byte = device_addr_lo[sel +: 8];
      default: gen_item.pkt_byte = 8'd0;
    endcase
    // payload byte that closes the burst
    if (burst_pos == final_pos) begin
      gen_item.pkt_byte = burst_byte;
      gen_item.pkt_last = burst_last;
    end
  end

  // burst counter
  always_ff @(posedge clk) begin
    if (rst) begin
      burst_active <= 1'b0;
      burst_pos    <= 6'd0;
    end else if (accept && emit_burst) begin
      burst_active <= 1'b1;
      burst_pos    <= 6'd1;
    end else if (burst_active && out_free) begin
      burst_pos <= burst_pos + 6'd1;
      if (burst_pos == final_pos) burst_active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit_burst) begin
      burst_byte <= in_data.frame_byte;
      burst_last <= in_data.frame_last;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && (emit_single || emit_burst)) begin
      out_valid <= 1'b1;
    end else if (burst_active && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit_single) begin
      out_data.pkt_byte  <= in_data.frame_byte;
      out_data.pkt_first <= 1'b0;
      out_data.pkt_last  <= in_data.frame_last;
      out_data.to_sender <= !mcast_next;
    end else if (accept && emit_burst) begin
      out_data.pkt_byte  <= HDR_VERSION;
      out_data.pkt_first <= 1'b1;
      out_data.pkt_last  <= 1'b0;
      out_data.to_sender <= !mcast_next;
    end else if (burst_active && out_free) begin
      out_data <= gen_item;
    end
  end

endmodule
`default_nettype wire
